FILE: rtl/rpfc_pkg.sv
// Shared types and constants for the RF pulse frame capture block.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package rpfc_pkg;

    localparam int MAX_EDGES_DEF   = 64;
    localparam int EDGE_TIME_W     = 32;
    localparam int PULSE_INDEX_W   = 6;
    localparam int CFG_INDEX_W     = 8;
    localparam int CFG_DATA_W      = 32;
    localparam int SYNC_GAP_MIN_W  = 20;
    localparam int SYNC_TOL_W      = 16;
    localparam int MIN_PULSE_W     = 16;

    // Register indexes on the configuration channel
    localparam logic [CFG_INDEX_W-1:0] REG_LISTEN_ENABLE  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SYNC_GAP_MIN   = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SYNC_TOLERANCE = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_PULSE      = 8'd3;

    // Register reset values
    localparam logic                      LISTEN_ENABLE_RST  = 1'b1;
    localparam logic [SYNC_GAP_MIN_W-1:0] SYNC_GAP_MIN_RST   = 20'd5000;
    localparam logic [SYNC_TOL_W-1:0]     SYNC_TOLERANCE_RST = 16'd200;
    localparam logic [MIN_PULSE_W-1:0]    MIN_PULSE_RST      = 16'd50;

    typedef struct packed {
        logic                      listen_enable;
        logic [SYNC_GAP_MIN_W-1:0] sync_gap_min;
        logic [SYNC_TOL_W-1:0]     sync_tolerance;
        logic [MIN_PULSE_W-1:0]    min_pulse;
    } rpfc_cfg_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } rpfc_mem_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_DECIDE,
        ST_SHOW,
        ST_STORE
    } rpfc_state_t;

endpackage

FILE: rtl/rpfc_edge_if.sv
// Edge timestamp channel: valid/ready handshake with one timestamp.
// Depends on rpfc_pkg.
`timescale 1ns / 1ps

interface rpfc_edge_if
    import rpfc_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [EDGE_TIME_W-1:0] edge_time;

    modport source (output valid, output edge_time, input ready);
    modport sink   (input valid, input edge_time, output ready);
endinterface

FILE: rtl/rpfc_pulse_if.sv
// Pulse duration channel: valid/ready handshake with one duration, its index and a frame-last flag.
// Depends on rpfc_pkg.
`timescale 1ns / 1ps

interface rpfc_pulse_if
    import rpfc_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [EDGE_TIME_W-1:0]   pulse_duration;
    logic [PULSE_INDEX_W-1:0] pulse_index;
    logic                     frame_last;

    modport source (output valid, output pulse_duration, output pulse_index,
                    output frame_last, input ready);
    modport sink   (input valid, input pulse_duration, input pulse_index,
                    input frame_last, output ready);
endinterface

FILE: rtl/rpfc_cfg_if.sv
// Configuration write channel: valid/ready handshake with index and data.
// Depends on rpfc_pkg.
`timescale 1ns / 1ps

interface rpfc_cfg_if
    import rpfc_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/rpfc_buffer.sv
// Pulse buffer: single write port, single read port, registered read data.
// Depends on rpfc_pkg for the control struct.
`timescale 1ns / 1ps

module rpfc_buffer
    import rpfc_pkg::*;
#(
    parameter int DEPTH = MAX_EDGES_DEF,
    parameter int AW    = $clog2(MAX_EDGES_DEF)
)
(
    input  logic                   clk,
    input  rpfc_mem_ctl_t          mem_ctl,
    input  logic [AW-1:0]          wr_addr,
    input  logic [EDGE_TIME_W-1:0] wr_data,
    input  logic [AW-1:0]          rd_addr,
    output logic [EDGE_TIME_W-1:0] rd_data
);

    logic [EDGE_TIME_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (mem_ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Hold read data until the next read is issued
    always_ff @(posedge clk)
    begin
        if (mem_ctl.rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/rpfc_ctrl.sv
// Capture sequencer: gap calculation, sync detection, counters and frame readout.
// Depends on rpfc_pkg and the edge and pulse channel interfaces, and drives rpfc_buffer ports.
`timescale 1ns / 1ps

module rpfc_ctrl
    import rpfc_pkg::*;
#(
    parameter int MAX_EDGES = MAX_EDGES_DEF,
    parameter int AW        = $clog2(MAX_EDGES_DEF),
    parameter int CW        = $clog2(MAX_EDGES_DEF + 1)
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  rpfc_cfg_t              cfg,
    rpfc_edge_if.sink              edges,
    rpfc_pulse_if.source           pulses,
    output rpfc_mem_ctl_t          mem_ctl,
    output logic [AW-1:0]          wr_addr,
    output logic [EDGE_TIME_W-1:0] wr_data,
    output logic [AW-1:0]          rd_addr,
    input  logic [EDGE_TIME_W-1:0] rd_data
);

    rpfc_state_t            state_reg, state_next;
    logic [EDGE_TIME_W-1:0] now_reg, now_next;
    logic [EDGE_TIME_W-1:0] last_reg, last_next;
    logic [EDGE_TIME_W-1:0] gap_reg, gap_next;
    logic [EDGE_TIME_W-1:0] first_reg, first_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic                   rep_reg, rep_next;
    logic [CW-1:0]          n_reg, n_next;
    logic [AW-1:0]          idx_reg, idx_next;
    logic                   store_reg, store_next;

    logic [EDGE_TIME_W:0]   gap_ext, first_ext, tol_ext;
    logic                   is_sync, is_match, do_store, do_emit;
    logic [CW-1:0]          cnt_dec, cnt_after;
    logic                   rep_after;
    logic                   full;
    logic                   is_last;

    // Decision terms, valid in ST_DECIDE; the window compare is one bit wider
    assign gap_ext   = {1'b0, gap_reg};
    assign first_ext = {1'b0, first_reg};
    assign tol_ext   = (EDGE_TIME_W + 1)'(cfg.sync_tolerance);
    assign is_sync   = gap_reg > EDGE_TIME_W'(cfg.sync_gap_min);
    assign is_match  = is_sync && (gap_ext + tol_ext > first_ext)
                       && (gap_ext < first_ext + tol_ext);
    assign do_store  = gap_reg > EDGE_TIME_W'(cfg.min_pulse);
    assign cnt_dec   = (cnt_reg != '0) ? cnt_reg - 1'b1 : '0;
    // A sync repeat with one repeat already seen is the second one
    assign do_emit   = is_match && rep_reg && (cnt_dec != '0);
    assign full      = !is_sync && (cnt_reg >= CW'(MAX_EDGES));
    assign cnt_after = (is_sync || full) ? '0 : cnt_reg;
    assign rep_after = is_match ? !rep_reg : (full ? 1'b0 : rep_reg);
    assign is_last   = CW'(idx_reg) == n_reg - 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            last_reg  <= '0;
            first_reg <= '0;
            cnt_reg   <= '0;
            rep_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            last_reg  <= last_next;
            first_reg <= first_next;
            cnt_reg   <= cnt_next;
            rep_reg   <= rep_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg   <= now_next;
        gap_reg   <= gap_next;
        n_reg     <= n_next;
        idx_reg   <= idx_next;
        store_reg <= store_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        now_next      = now_reg;
        last_next     = last_reg;
        gap_next      = gap_reg;
        first_next    = first_reg;
        cnt_next      = cnt_reg;
        rep_next      = rep_reg;
        n_next        = n_reg;
        idx_next      = idx_reg;
        store_next    = store_reg;
        mem_ctl.wr_en = 1'b0;
        mem_ctl.rd_en = 1'b0;
        wr_addr       = cnt_after[AW-1:0];
        wr_data       = gap_reg;
        rd_addr       = idx_reg;
        edges.ready   = 1'b0;
        pulses.valid  = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                edges.ready = 1'b1;
                // Drop the transfer entirely while listening is off
                if (edges.valid && cfg.listen_enable)
                begin
                    now_next   = edges.edge_time;
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                gap_next   = now_reg - last_reg;
                last_next  = now_reg;
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                rep_next = rep_after;
                if (do_emit)
                begin
                    mem_ctl.rd_en = 1'b1;
                    rd_addr       = '0;
                    idx_next      = '0;
                    n_next        = cnt_dec;
                    store_next    = do_store;
                    cnt_next      = '0;
                    state_next    = ST_SHOW;
                end
                else
                begin
                    if (do_store)
                    begin
                        mem_ctl.wr_en = 1'b1;
                        cnt_next      = cnt_after + 1'b1;
                        if (cnt_after == '0)
                        begin
                            first_next = gap_reg;
                        end
                    end
                    else
                    begin
                        cnt_next = cnt_after;
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_SHOW:
            begin
                pulses.valid = 1'b1;
                if (pulses.ready)
                begin
                    if (is_last)
                    begin
                        state_next = ST_STORE;
                    end
                    else
                    begin
                        // Advance the read as the current entry transfers
                        mem_ctl.rd_en = 1'b1;
                        rd_addr       = idx_reg + 1'b1;
                        idx_next      = idx_reg + 1'b1;
                    end
                end
            end
            ST_STORE:
            begin
                // Entry 0 is written only after the frame has been read out
                wr_addr = '0;
                if (store_reg)
                begin
                    mem_ctl.wr_en = 1'b1;
                    cnt_next      = CW'(1);
                    first_next    = gap_reg;
                end
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign pulses.pulse_duration = rd_data;
    assign pulses.pulse_index    = PULSE_INDEX_W'(idx_reg);
    assign pulses.frame_last     = is_last;

`ifndef NO_ASSERTIONS
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_ctl.wr_en && mem_ctl.rd_en))
        else $error("buffer read and write in the same cycle");

    a_no_edge_during_frame: assert property (@(posedge clk) disable iff (!rst_n)
        pulses.valid |-> !edges.ready)
        else $error("edge accepted while a frame is being emitted");

    a_last_then_store: assert property (@(posedge clk) disable iff (!rst_n)
        (pulses.valid && pulses.ready && pulses.frame_last) |=> state_reg == ST_STORE)
        else $error("final duration not followed by the store cycle");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(MAX_EDGES))
        else $error("edge count beyond buffer depth");

    a_first_shadow: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_ctl.wr_en && wr_addr == '0) |=> first_reg == $past(wr_data))
        else $error("first-gap shadow out of step with buffer entry 0");
`endif

endmodule

FILE: rtl/rf_pulse_frame_capture_top.sv
// Top level of the RF pulse frame capture block: configuration registers and
// the sequencer and buffer instances. Depends on rpfc_pkg, the interfaces,
// rpfc_buffer and rpfc_ctrl.
`timescale 1ns / 1ps

// An edge timestamp passes from transfer to the next ready through accept, gap
// subtraction, then the sync/store decision and buffer write; edges arriving while
// listen_enable is low are taken and dropped. On the second sync repeat with N
// durations stored, the frame is read out of the pulse buffer, which has separate
// read and write ports, one entry per cycle while the sink is ready, N at most
// MAX_EDGES - 1. The new gap is written to buffer entry 0 only after the frame has
// been read. The buffer needs no clearing pass after reset: entry 0 is shadowed in
// a register that resets to zero, and every other entry is read only after it has
// been written.
module rf_pulse_frame_capture_top
    import rpfc_pkg::*;
#(
    parameter int MAX_EDGES = MAX_EDGES_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    rpfc_edge_if.sink    edges,
    rpfc_pulse_if.source pulses,
    rpfc_cfg_if.sink     cfg
);

    localparam int AW = $clog2(MAX_EDGES);
    localparam int CW = $clog2(MAX_EDGES + 1);

    rpfc_cfg_t              cfg_reg;
    rpfc_mem_ctl_t          mem_ctl;
    logic [AW-1:0]          wr_addr;
    logic [AW-1:0]          rd_addr;
    logic [EDGE_TIME_W-1:0] wr_data;
    logic [EDGE_TIME_W-1:0] rd_data;

    assign cfg.ready = 1'b1;

    // Unknown indexes are ignored; data is truncated to the register width
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.listen_enable  <= LISTEN_ENABLE_RST;
            cfg_reg.sync_gap_min   <= SYNC_GAP_MIN_RST;
            cfg_reg.sync_tolerance <= SYNC_TOLERANCE_RST;
            cfg_reg.min_pulse      <= MIN_PULSE_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_LISTEN_ENABLE:  cfg_reg.listen_enable  <= cfg.data[0];
                REG_SYNC_GAP_MIN:   cfg_reg.sync_gap_min   <= cfg.data[SYNC_GAP_MIN_W-1:0];
                REG_SYNC_TOLERANCE: cfg_reg.sync_tolerance <= cfg.data[SYNC_TOL_W-1:0];
                REG_MIN_PULSE:      cfg_reg.min_pulse      <= cfg.data[MIN_PULSE_W-1:0];
                default:            ;
            endcase
        end
    end

    rpfc_ctrl #(
        .MAX_EDGES (MAX_EDGES),
        .AW        (AW),
        .CW        (CW)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .edges   (edges),
        .pulses  (pulses),
        .mem_ctl (mem_ctl),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    rpfc_buffer #(
        .DEPTH (MAX_EDGES),
        .AW    (AW)
    ) u_buffer (
        .clk     (clk),
        .mem_ctl (mem_ctl),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule
